// ===== rtl/sbcs_pkg.sv =====
// Package for the swept box collide/slide core: fixed-point constants and state codes.
// Used by rtl/sbcs_div.sv and rtl/swept_box_collide_slide_core.sv; depends on nothing.
package sbcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = 64;
    localparam int CNT_W     = 7;
    localparam logic signed [63:0] ONE_FX  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] EPS_FX  = ((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    localparam logic [0:0] CFG_MOVER_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_MOVER_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_T0_WAIT,
        ST_T1_START,
        ST_T1_WAIT,
        ST_SLAB,
        ST_FACE,
        ST_CLIP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic logic signed [63:0] absv(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

// ===== rtl/swept_box_collide_slide_core.sv =====
// Top level of the swept box collide/slide core: sequencer, state and stream ports.
// Depends on rtl/sbcs_pkg.sv and rtl/sbcs_div.sv.
//
// One box per transfer; the next box is taken only once the previous one is through,
// its time set by the shared radix-2 divider: each moving axis runs two slab divisions
// while a hit is still possible, a still axis is an overlap check, and the clip is one
// multiply and one shift. The block is not ready while a box is in work; the result is
// held in an output register until taken, and a finished box waits while that register
// is still full.
// Arithmetic is Q15.16, saturating.
module swept_box_collide_slide_core
    import sbcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [9:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: start_x, start_y, move_x, move_y, box_x, box_y, box_w, box_h (+2 pad bits)
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // first
    input  logic         s_axis_tlast,   // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: slide_x, slide_y, end_x, end_y
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tuser,   // hit
    output logic         m_axis_tlast    // run_end
);

    state_t state_reg, state_next;
    logic [9:0] mw_reg, mh_reg;
    logic signed [63:0] pos_reg [2];
    logic signed [63:0] mv_reg [2];
    logic signed [63:0] lo_reg [2], hi_reg [2];
    logic signed [63:0] t0_reg, tfar_reg, tnear_reg, mul_reg;
    logic coll_reg, last_reg, k_reg, ax_reg, hit_reg;
    logic [127:0] odata_reg;
    logic ovalid_reg, ouser_reg, olast_reg;

    logic div_start;
    logic signed [63:0] div_num, div_den, quo;
    div_ctl_t div_ctl;

    sbcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .ctl   (div_ctl),
        .quo   (quo)
    );

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    logic signed [63:0] pk, dk, lok, hik, t1s, ta, tb, ntfar, ntnear, mn0, mn1, mx0, mx1, nd;
    logic signed [63:0] clip;
    logic signed [FRAC_BITS+1:0] omt;
    logic signed [31:0] mvs;
    logic signed [FRAC_BITS+33:0] prod;
    logic a_sel, b_sel, ax_sel;

    always_comb
    begin
        pk = pos_reg[k_reg];
        dk = mv_reg[k_reg];
        lok = lo_reg[k_reg];
        hik = hi_reg[k_reg];
        t1s = sat32(quo);
        ta = (t0_reg > t1s) ? t1s : t0_reg;
        tb = (t0_reg > t1s) ? t0_reg : t1s;
        ntfar = (ta > tfar_reg) ? ta : tfar_reg;
        ntnear = (tb < tnear_reg) ? tb : tnear_reg;
        mn0 = absv(pos_reg[0] - lo_reg[0]);
        mn1 = absv(pos_reg[1] - lo_reg[1]);
        mx0 = absv(hi_reg[0] - pos_reg[0]);
        mx1 = absv(hi_reg[1] - pos_reg[1]);
        a_sel = !(mn0 <= mn1);
        b_sel = !(mx0 <= mx1);
        ax_sel = ((a_sel ? mn1 : mn0) < (b_sel ? mx1 : mx0)) ? a_sel : b_sel;
        omt = (FRAC_BITS+2)'(ONE_FX - tfar_reg);
        mvs = mv_reg[ax_sel][31:0];
        prod = omt * mvs;
        clip = (mul_reg + ((mul_reg < 0) ? ONE_FX - 64'sd1 : 64'sd0)) >>> FRAC_BITS;
        nd = sat32(mv_reg[ax_reg] - clip);
        div_start = 1'b0;
        div_num = (lok - pk) <<< FRAC_BITS;
        div_den = dk;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid) state_next = ST_AXIS;
            ST_AXIS:
                if (!coll_reg)
                    state_next = ST_FACE;
                else if (absv(dk) <= EPS_FX)
                    state_next = ST_SLAB;
                else
                begin
                    div_start = 1'b1;
                    state_next = ST_T0_WAIT;
                end
            ST_T0_WAIT:
                if (div_ctl.done) state_next = ST_T1_START;
            ST_T1_START:
            begin
                div_num = (hik - pk) <<< FRAC_BITS;
                div_start = 1'b1;
                state_next = ST_T1_WAIT;
            end
            ST_T1_WAIT:
                if (div_ctl.done) state_next = ST_SLAB;
            ST_SLAB:
                state_next = (k_reg == 1'b0) ? ST_AXIS : ST_FACE;
            ST_FACE:
                if (coll_reg && tfar_reg >= 0 && tfar_reg <= ONE_FX)
                    state_next = ST_CLIP;
                else
                    state_next = ST_OUT;
            ST_CLIP:
                state_next = ST_OUT;
            ST_OUT:
                if (!ovalid_reg || m_axis_tready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mw_reg <= 10'd32;
            mh_reg <= 10'd32;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            mv_reg[0] <= '0;
            mv_reg[1] <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MOVER_WIDTH) mw_reg <= cfg_data;
                if (cfg_index == CFG_MOVER_HEIGHT) mh_reg <= cfg_data;
            end
            if (state_reg == ST_IDLE && s_axis_tvalid && s_axis_tuser)
            begin
                pos_reg[0] <= 64'(signed'(s_axis_tdata[31:0]));
                pos_reg[1] <= 64'(signed'(s_axis_tdata[63:32]));
                mv_reg[0]  <= 64'(signed'(s_axis_tdata[95:64]));
                mv_reg[1]  <= 64'(signed'(s_axis_tdata[127:96]));
            end
            if (state_reg == ST_CLIP)
                mv_reg[ax_reg] <= nd;
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                ovalid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                lo_reg[0] <= 64'(signed'(s_axis_tdata[159:128]))
                    - (64'($unsigned(mw_reg)) <<< FRAC_BITS);
                lo_reg[1] <= 64'(signed'(s_axis_tdata[191:160]))
                    - (64'($unsigned(mh_reg)) <<< FRAC_BITS);
                hi_reg[0] <= 64'(signed'(s_axis_tdata[159:128]))
                    + 64'($unsigned(s_axis_tdata[222:192]));
                hi_reg[1] <= 64'(signed'(s_axis_tdata[191:160]))
                    + 64'($unsigned(s_axis_tdata[253:223]));
                last_reg <= s_axis_tlast;
                tfar_reg <= '0;
                tnear_reg <= S32_MAX;
                coll_reg <= 1'b1;
                k_reg <= 1'b0;
                hit_reg <= 1'b0;
            end
            ST_AXIS:
                if (coll_reg && absv(dk) <= EPS_FX && (pk < lok || pk > hik))
                    coll_reg <= 1'b0;
            ST_T0_WAIT:
                if (div_ctl.done) t0_reg <= sat32(quo);
            ST_T1_WAIT:
                if (div_ctl.done)
                begin
                    tfar_reg <= ntfar;
                    tnear_reg <= ntnear;
                    if (ntfar - ntnear >= -EPS_FX) coll_reg <= 1'b0;
                end
            ST_SLAB:
                k_reg <= 1'b1;
            ST_FACE:
            begin
                ax_reg <= ax_sel;
                mul_reg <= 64'(prod);
            end
            ST_CLIP:
                hit_reg <= 1'b1;
            ST_OUT:
                if (state_next == ST_IDLE)
                begin
                    odata_reg[31:0] <= mv_reg[0][31:0];
                    odata_reg[63:32] <= mv_reg[1][31:0];
                    odata_reg[95:64] <= last_reg ? 32'(sat32(pos_reg[0] + mv_reg[0])) : '0;
                    odata_reg[127:96] <= last_reg ? 32'(sat32(pos_reg[1] + mv_reg[1])) : '0;
                    ouser_reg <= hit_reg;
                    olast_reg <= last_reg;
                end
            default:
                ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_div_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> (state_reg == ST_T0_WAIT || state_reg == ST_T1_WAIT))
        else $error("stray divider result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule

// ===== rtl/sbcs_div.sv =====
// Radix-2 signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on rtl/sbcs_pkg.sv.
module sbcs_div
    import sbcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [NUM_W-1:0] den,
    output div_ctl_t                ctl,
    output logic signed [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [NUM_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {rem_reg[NUM_W-2:0], q_reg[NUM_W-1]};
        trial     = {1'b0, sh} - {1'b0, d_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num[NUM_W-1] ? -num : num;
            d_next    = den[NUM_W-1] ? -den : den;
            neg_next  = num[NUM_W-1] ^ den[NUM_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Remainder shift drops its top bit only when it is zero: remainder < divisor.
            if (!trial[NUM_W] || rem_reg[NUM_W-1])
            begin
                rem_next = trial[NUM_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
